/* hdl/zk_identification_round_verifier_unit_macros.svh */
`ifndef ZK_IDENTIFICATION_ROUND_VERIFIER_UNIT_MACROS_SVH
`define ZK_IDENTIFICATION_ROUND_VERIFIER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ZKV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ZKV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/zkv_pkg.sv */
package zkv_pkg;

  localparam int DATA_BITS        = 64;
  localparam int STEP_BITS        = $clog2(DATA_BITS);
  localparam int COUNT_REG_BITS   = 8;
  localparam int ROUND_INDEX_BITS = 8;
  localparam int CFG_IDX_BITS     = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PUBLIC_KEY  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROUND_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REDUCE,
    ST_MUL_LOAD,
    ST_MUL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start_reduce;
    logic start_mul;
    logic step;
  } lane_cmd_t;

endpackage

/* hdl/zkv_modmul_lane.sv */
module zkv_modmul_lane
  import zkv_pkg::*;
#(
  parameter int MOD_BITS = 64
) (
  input  logic                 clk,
  input  lane_cmd_t            cmd,
  input  logic [MOD_BITS-1:0]  n,
  input  logic [DATA_BITS-1:0] first_op,
  input  logic [DATA_BITS-1:0] second_op,
  output logic [MOD_BITS-1:0]  result
);

  logic [MOD_BITS-1:0]  acc;
  logic [MOD_BITS-1:0]  addend;
  logic [DATA_BITS-1:0] bits;

  function automatic logic [MOD_BITS-1:0] add_mod(input logic [MOD_BITS-1:0] p,
                                                  input logic [MOD_BITS-1:0] q,
                                                  input logic [MOD_BITS-1:0] m);
    logic [MOD_BITS:0] s;
    logic [MOD_BITS:0] t;
    s = {1'b0, p} + {1'b0, q};
    t = s - {1'b0, m};
    add_mod = (s >= {1'b0, m}) ? t[MOD_BITS-1:0] : s[MOD_BITS-1:0];
  endfunction

  // first pass reduces first_op by n, second pass multiplies that residue by second_op
  always_ff @(posedge clk) begin
    if (cmd.start_reduce) begin
      acc    <= '0;
      addend <= MOD_BITS'(1);
      bits   <= first_op;
    end else if (cmd.start_mul) begin
      acc    <= '0;
      addend <= acc;
      bits   <= second_op;
    end else if (cmd.step) begin
      if (bits[0]) begin
        acc <= add_mod(acc, addend, n);
      end
      addend <= add_mod(addend, addend, n);
      bits   <= bits >> 1;
    end
  end

  assign result = acc;

endmodule

/* hdl/zkv_ctrl.sv */
module zkv_ctrl
  import zkv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      slot_free,
  output logic      in_ready,
  output lane_cmd_t cmd,
  output logic      finish
);

  state_t               state;
  state_t               state_next;
  logic [STEP_BITS-1:0] step_cnt;
  logic                 last_step;

  assign last_step = (step_cnt == STEP_BITS'(DATA_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_reduce || cmd.start_mul) begin
      step_cnt <= '0;
    end else if (cmd.step) begin
      step_cnt <= step_cnt + STEP_BITS'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_LOAD;
      ST_LOAD:     state_next = ST_REDUCE;
      ST_REDUCE:   if (last_step) state_next = ST_MUL_LOAD;
      ST_MUL_LOAD: state_next = ST_MUL;
      ST_MUL:      if (last_step) state_next = ST_FINISH;
      ST_FINISH:   if (slot_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state == ST_IDLE) && !rst;
    cmd.start_reduce = (state == ST_LOAD);
    cmd.start_mul    = (state == ST_MUL_LOAD);
    cmd.step         = (state == ST_REDUCE) || (state == ST_MUL);
    finish           = (state == ST_FINISH) && slot_free;
  end

endmodule

/* hdl/zk_identification_round_verifier_unit.sv */
// Round verifier for a multi-round identification proof. Each accepted round (commitment x,
// response y, challenge bit) is checked as y*y mod n against x (challenge 0) or against
// x*v mod n (challenge 1), and produces one result carrying round_ok, the round's index and,
// on the last round of a proof, proof_done with the proof verdict. The block works on one round
// at a time: the next round can be accepted in the cycle after the previous result enters
// the output register. Each round is computed by two serial modular multiplier lanes running
// side by side, each making two passes of 64 shift-and-add steps (reduce an operand, then
// multiply) with a load state before each pass, after which the result is registered. A
// result held by the receiver stalls the controller in its finish state.
module zk_identification_round_verifier_unit
  import zkv_pkg::*;
#(
  parameter int MOD_BITS   = 64,
  parameter int ROUND_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [DATA_BITS-1:0]        cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [DATA_BITS-1:0]        commitment,
  input  logic [DATA_BITS-1:0]        response,
  input  logic                        challenge_bit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        round_ok,
  output logic [ROUND_INDEX_BITS-1:0] round_index,
  output logic                        proof_done,
  output logic                        proof_ok
);

  localparam int IDX_W = (ROUND_BITS > ROUND_INDEX_BITS) ? ROUND_BITS : ROUND_INDEX_BITS;
  localparam int CMP_W = ((ROUND_BITS > COUNT_REG_BITS) ? ROUND_BITS : COUNT_REG_BITS) + 1;

  logic [MOD_BITS-1:0]       modulus;
  logic [MOD_BITS-1:0]       public_key_value;
  logic [COUNT_REG_BITS-1:0] round_count;

  logic [DATA_BITS-1:0]  x_reg;
  logic [DATA_BITS-1:0]  y_reg;
  logic                  e_reg;

  logic [ROUND_BITS-1:0] round_counter;
  logic [ROUND_BITS-1:0] round_counter_next;
  logic                  all_passed;
  logic                  all_passed_next;

  lane_cmd_t             cmd;
  logic                  finish;
  logic                  slot_free;
  logic [MOD_BITS-1:0]   lhs_raw;
  logic [MOD_BITS-1:0]   rhs_raw;
  logic [MOD_BITS-1:0]   lhs;
  logic [MOD_BITS-1:0]   rhs;
  logic                  degenerate;
  logic                  ok;
  logic                  done;
  logic                  verdict;
  logic [COUNT_REG_BITS-1:0] need;
  logic [IDX_W-1:0]      cnt_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= MOD_BITS'(2);
      public_key_value <= '0;
      round_count      <= COUNT_REG_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:     modulus          <= cfg_data[MOD_BITS-1:0];
        REG_PUBLIC_KEY:  public_key_value <= cfg_data[MOD_BITS-1:0];
        REG_ROUND_COUNT: round_count      <= cfg_data[COUNT_REG_BITS-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_reg <= commitment;
      y_reg <= response;
      e_reg <= challenge_bit;
    end
  end

  assign slot_free = !out_valid || out_ready;

  zkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .slot_free (slot_free),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .finish    (finish)
  );

  zkv_modmul_lane #(.MOD_BITS(MOD_BITS)) u_lane_square (
    .clk       (clk),
    .cmd       (cmd),
    .n         (modulus),
    .first_op  (y_reg),
    .second_op (y_reg),
    .result    (lhs_raw)
  );

  zkv_modmul_lane #(.MOD_BITS(MOD_BITS)) u_lane_key (
    .clk       (clk),
    .cmd       (cmd),
    .n         (modulus),
    .first_op  (DATA_BITS'(public_key_value)),
    .second_op (x_reg),
    .result    (rhs_raw)
  );

  // a modulus below two leaves every residue at zero
  assign degenerate = (modulus < MOD_BITS'(2));
  assign lhs        = degenerate ? '0 : lhs_raw;
  assign rhs        = degenerate ? '0 : rhs_raw;
  assign ok         = e_reg ? (lhs == rhs) : (DATA_BITS'(lhs) == x_reg);

  assign need     = (round_count == '0) ? COUNT_REG_BITS'(1) : round_count;
  assign done     = ((CMP_W'(round_counter) + CMP_W'(1)) >= CMP_W'(need)) ||
                    (round_counter == {ROUND_BITS{1'b1}});
  assign verdict  = all_passed && ok;
  assign cnt_wide = IDX_W'(round_counter);

  assign round_counter_next = done ? '0 : round_counter + ROUND_BITS'(1);
  assign all_passed_next    = done ? 1'b1 : verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_counter <= '0;
      all_passed    <= 1'b1;
      out_valid     <= 1'b0;
    end else if (finish) begin
      round_counter <= round_counter_next;
      all_passed    <= all_passed_next;
      out_valid     <= 1'b1;
    end else if (out_ready) begin
      out_valid     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      round_ok    <= ok;
      round_index <= cnt_wide[ROUND_INDEX_BITS-1:0];
      proof_done  <= done;
      proof_ok    <= done && verdict;
    end
  end

endmodule

/* hdl/zkv_checker.sv */
`include "zk_identification_round_verifier_unit_macros.svh"

module zkv_checker
  import zkv_pkg::*;
(
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        round_ok,
  input logic [ROUND_INDEX_BITS-1:0] round_index,
  input logic                        proof_done,
  input logic                        proof_ok
);

  `ZKV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable({round_ok, round_index, proof_done, proof_ok}))
  `ZKV_ASSERT_NOW(a_verdict_with_done, clk, rst, out_valid && proof_ok, proof_done)
  `ZKV_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ZKV_ASSERT_NEXT(a_no_instant_result, clk, rst, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind zk_identification_round_verifier_unit zkv_checker u_zkv_checker (.*);

/* dv/tb_zk_identification_round_verifier_unit.sv */
`timescale 1ns / 100ps

module tb_zk_identification_round_verifier_unit;
  import zkv_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int LONG_HOLD    = 700;
  localparam int LAST_HOLD_AT = 700;

  typedef struct packed {
    logic [DATA_BITS-1:0] commit;
    logic [DATA_BITS-1:0] resp;
    logic                 chal;
  } round_item_t;

  typedef struct packed {
    logic                        ok;
    logic [ROUND_INDEX_BITS-1:0] index;
    logic                        done;
    logic                        proof;
  } verdict_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]     cfg_index = REG_MODULUS;
  logic [DATA_BITS-1:0]        cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [DATA_BITS-1:0]        commitment = '0;
  logic [DATA_BITS-1:0]        response = '0;
  logic                        challenge_bit = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        round_ok;
  logic [ROUND_INDEX_BITS-1:0] round_index;
  logic                        proof_done;
  logic                        proof_ok;

  // mirror of the block's registers and proof state
  logic [DATA_BITS-1:0] mod_n = 64'd2;
  logic [DATA_BITS-1:0] key_v = '0;
  logic [7:0]           rounds_cfg = 8'd1;
  logic [7:0]           round_ctr = '0;
  logic                 proof_clean = 1'b1;
  logic [DATA_BITS-1:0] key_secret = '0;

  round_item_t pending_rounds[$];
  verdict_t    expected_verdicts[$];

  logic in_taken = 1'b0;
  bit   idle_on = 1'b1;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   hold_at = 250;
  int   results_checked = 0;
  int   err_count = 0;
  int   cycle_count = 0;

  zk_identification_round_verifier_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .commitment    (commitment),
    .response      (response),
    .challenge_bit (challenge_bit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .round_ok      (round_ok),
    .round_index   (round_index),
    .proof_done    (proof_done),
    .proof_ok      (proof_ok)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [DATA_BITS-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [DATA_BITS-1:0] prod_mod(input logic [DATA_BITS-1:0] a, b, n);
    logic [2*DATA_BITS-1:0] ar, br, p;
    if (n < 64'd2) return '0;
    ar = {{DATA_BITS{1'b0}}, a % n};
    br = {{DATA_BITS{1'b0}}, b % n};
    p  = ar * br;
    p  = p % {{DATA_BITS{1'b0}}, n};
    return p[DATA_BITS-1:0];
  endfunction

  function automatic verdict_t predict_round(input logic [DATA_BITS-1:0] x, y, input logic e);
    verdict_t             res;
    logic [DATA_BITS-1:0] lhs, rhs;
    logic [8:0]           need;
    logic                 ok, done;
    lhs  = prod_mod(y, y, mod_n);
    rhs  = e ? prod_mod(x, key_v, mod_n) : x;
    ok   = (lhs == rhs);
    need = (rounds_cfg == 8'd0) ? 9'd1 : {1'b0, rounds_cfg};
    done = ({1'b0, round_ctr} + 9'd1 >= need) || (round_ctr == 8'hFF);
    res.ok    = ok;
    res.index = round_ctr;
    res.done  = done;
    res.proof = done && proof_clean && ok;
    if (done) begin
      round_ctr   = '0;
      proof_clean = 1'b1;
    end else begin
      round_ctr   = round_ctr + 8'd1;
      proof_clean = proof_clean && ok;
    end
    return res;
  endfunction

  // drive transactions on the falling edge
  always @(negedge clk) begin : drive
    round_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold until accepted
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (pending_rounds.size() != 0) begin
      nxt = pending_rounds.pop_front();
      commitment    <= nxt.commit;
      response      <= nxt.resp;
      challenge_bit <= nxt.chal;
      in_valid      <= 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : receive
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_at <= LAST_HOLD_AT && results_checked >= hold_at &&
                 pending_rounds.size() != 0) begin
      out_ready <= 1'b0;
      hold_left = LONG_HOLD;
      hold_at   = hold_at + 450;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 11) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      cycle_count++;
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        expected_verdicts.push_back(predict_round(commitment, response, challenge_bit));
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected transaction: round_index %0d", round_index);
          err_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (round_ok !== want.ok) begin
            $error("round_ok: expected %0d, actual %0d", want.ok, round_ok);
            err_count++;
          end
          if (round_index !== want.index) begin
            $error("round_index: expected %0d, actual %0d", want.index, round_index);
            err_count++;
          end
          if (proof_done !== want.done) begin
            $error("proof_done: expected %0d, actual %0d", want.done, proof_done);
            err_count++;
          end
          if (proof_ok !== want.proof) begin
            $error("proof_ok: expected %0d, actual %0d", want.proof, proof_ok);
            err_count++;
          end
        end
        results_checked++;
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MODULUS:     mod_n = data;
      REG_PUBLIC_KEY:  key_v = data;
      REG_ROUND_COUNT: rounds_cfg = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_rounds.size() != 0 || in_valid || expected_verdicts.size() != 0);
  endtask

  function automatic void add_round(input logic [DATA_BITS-1:0] x, y, input logic e);
    round_item_t it;
    it.commit = x;
    it.resp   = y;
    it.chal   = e;
    pending_rounds.push_back(it);
  endfunction

  // honest rounds built from a random r and the secret, some of them corrupted
  task automatic queue_rounds(input int count, input int bad_pct);
    logic [DATA_BITS-1:0] x, y, r;
    logic                 e;
    int                   k;
    for (int i = 0; i < count; i++) begin
      r = (mod_n >= 2) ? rand64() % mod_n : rand64();
      e = 1'($urandom_range(0, 1));
      x = prod_mod(r, r, mod_n);
      y = e ? prod_mod(r, key_secret, mod_n) : r;
      if ($urandom_range(0, 7) == 0 && y + mod_n > y) y = y + mod_n;
      if ($urandom_range(1, 100) <= bad_pct) begin
        k = $urandom_range(0, DATA_BITS - 1);
        case ($urandom_range(0, 4))
          0: x = x ^ (64'd1 << k);
          1: y = y ^ (64'd1 << k);
          2: begin
            x = rand64();
            y = rand64();
          end
          3: begin
            if (!e && x + mod_n > x) x = x + mod_n;
            else e = ~e;
          end
          default: e = ~e;
        endcase
      end
      add_round(x, y, e);
    end
  endtask

  initial begin : stimulus
    logic [DATA_BITS-1:0] n;
    logic [7:0]           rc;
    int                   random_sent;
    int                   phase;
    int                   count;
    random_sent = 0;
    phase = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: n = 2, v = 0, one round per proof
    add_round(64'd0, 64'd0, 1'b0);
    add_round(64'd1, 64'd1, 1'b0);
    add_round(64'd2, 64'd0, 1'b0);
    add_round('1, '1, 1'b1);
    add_round(64'd5, 64'd2, 1'b1);
    wait_drained();

    key_secret = rand64();
    write_reg(REG_MODULUS, '1);
    write_reg(REG_PUBLIC_KEY, prod_mod(key_secret, key_secret, '1));
    write_reg(REG_ROUND_COUNT, 64'd4);
    add_round('1, '1, 1'b0);
    add_round(64'd0, '1, 1'b0);
    add_round('1, 64'd0, 1'b1);
    queue_rounds(5, 30);
    wait_drained();

    // degenerate moduli, zero round count
    write_reg(REG_MODULUS, 64'd1);
    write_reg(REG_ROUND_COUNT, {rand64()} & ~64'hFF);
    add_round(64'd0, rand64(), 1'b0);
    add_round(64'd5, rand64(), 1'b0);
    add_round(rand64(), rand64(), 1'b1);
    wait_drained();
    write_reg(REG_MODULUS, 64'd0);
    add_round(64'd0, rand64(), 1'b0);
    add_round(rand64(), rand64(), 1'b1);
    wait_drained();

    // round count lowered part-way through a proof
    write_reg(REG_ROUND_COUNT, 64'd10);
    queue_rounds(3, 0);
    wait_drained();
    write_reg(REG_ROUND_COUNT, 64'd2);
    queue_rounds(2, 0);
    wait_drained();

    while (random_sent < RANDOM_ITEMS) begin
      phase++;
      idle_on = (random_sent >= RANDOM_ITEMS - 120) ? 1'b0 : ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0: n = '1;
        1: n = 64'($urandom_range(2, 1000));
        2: n = rand64() | 64'd1;
        3: n = rand64() | (64'd1 << 63);
        4: n = 64'd2;
        default: n = {32'd0, $urandom};
      endcase
      if (n < 2) n = 64'd2;
      write_reg(REG_MODULUS, n);
      key_secret = rand64();
      write_reg(REG_PUBLIC_KEY, ($urandom_range(0, 7) == 0) ? rand64() :
                prod_mod(key_secret, key_secret, n));
      if (phase == 3) rc = 8'd255;
      else begin
        case ($urandom_range(0, 5))
          0: rc = 8'd1;
          1: rc = 8'd0;
          2: rc = 8'($urandom_range(20, 255));
          default: rc = 8'($urandom_range(1, 16));
        endcase
      end
      write_reg(REG_ROUND_COUNT, {rand64()} & ~64'hFF | {56'd0, rc});
      count = (rc == 8'd255) ? 260 : $urandom_range(20, 100);
      if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
      queue_rounds(count, $urandom_range(5, 40));
      random_sent += count;
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (err_count == 0 && expected_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
